>>> hdl/mqtws_pkg.sv
package mqtws_pkg;

  localparam int unsigned ValueW   = 31;
  localparam int unsigned ElapsedW = 32;
  localparam int unsigned TotalW   = 64;
  localparam int unsigned ProdW    = ValueW + ElapsedW;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_DEQ_EMPTY = 2'd1;
  localparam logic [1:0] ERR_ENQ_FULL  = 2'd2;

  typedef struct packed {
    logic                op;
    logic [ElapsedW-1:0] elapsed;
    logic [ValueW-1:0]   value;
  } mqtws_in_t;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [ValueW-1:0] current_max;
    logic              is_empty;
    logic [1:0]        error;
  } mqtws_out_t;

endpackage

>>> hdl/max_queue_time_weighted_sum.sv
// fifo with running maximum (monotonic deque in one 1-port-read/1-port-write memory)
// and a saturating time integral of that maximum.
// an enqueue beat goes through multiply, accumulate, a binary search of a non-empty deque (one
// memory read per probe), tail write and result; a dequeue reloads the front after a pop,
// and refused beats skip straight to the result. one beat is worked on at a
// time (busy high meanwhile); the next beat can be taken at the edge ending the done_o cycle.
// reset clears all counters, the total and the strobe; deque storage is not cleared.
// the receiver cannot stall: each result shows on result_o with the one-cycle done_o strobe.
module max_queue_time_weighted_sum
  import mqtws_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  mqtws_in_t  item_i,
  output logic       done_o,
  output mqtws_out_t result_o
);

  // index width into storage, and count width that also holds QUEUE_DEPTH itself
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = ValueW + AW;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;  // max * elapsed
  localparam logic [2:0] ST_ACC  = 3'd2;  // saturating add, op decode, first probe
  localparam logic [2:0] ST_SRCH = 3'd3;  // one binary-search probe per cycle
  localparam logic [2:0] ST_WR   = 3'd4;  // write new deque tail
  localparam logic [2:0] ST_POP  = 3'd5;  // reload front after a pop
  localparam logic [2:0] ST_FIN  = 3'd6;  // build result

  // (first + k) mod depth, with both operands below depth
  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW-1:0] d;
    d = hi - lo;
    return lo + (d >> 1);
  endfunction

  logic [2:0]          state_q, state_d;
  mqtws_in_t           item_q, item_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [AW-1:0]       first_q, first_d;
  logic [CW-1:0]       dcnt_q, dcnt_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       qcnt_q, qcnt_d;
  logic [ValueW-1:0]   max_q, max_d;     // cached deque front value
  logic [AW-1:0]       fpos_q, fpos_d;   // cached deque front position
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [1:0]          err_q, err_d;
  logic                done_q, done_d;
  mqtws_out_t          res_q, res_d;

  // deque storage: {value, position}
  logic [MW-1:0]       mem [QUEUE_DEPTH];
  logic [MW-1:0]       rdata_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [MW-1:0]       wr_data;

  logic [ValueW-1:0]   rd_value;
  logic [AW-1:0]       rd_pos;
  logic [TotalW:0]     sum;
  logic [ValueW-1:0]   factor;
  logic [CW-1:0]       mid_cur;
  logic [CW-1:0]       dcnt_pop;
  logic [AW-1:0]       enq_pos;

  assign rd_value = rdata_q[MW-1:AW];
  assign rd_pos   = rdata_q[AW-1:0];
  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    prod_d  = prod_q;
    total_d = total_q;
    first_d = first_q;
    dcnt_d  = dcnt_q;
    head_d  = head_q;
    qcnt_d  = qcnt_q;
    max_d   = max_q;
    fpos_d  = fpos_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    err_d   = err_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    factor  = ((qcnt_q != '0) && (dcnt_q != '0)) ? max_q : '0;
    sum     = (TotalW+1)'(total_q) + (TotalW+1)'(prod_q);
    mid_cur = mid_of(lo_q, hi_q);
    dcnt_pop = dcnt_q - CW'(1);
    enq_pos = mod_add(head_q, qcnt_q);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d  = item_i;
          err_d   = ERR_OK;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(factor) * ProdW'(item_q.elapsed);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        total_d = sum[TotalW] ? '1 : sum[TotalW-1:0];
        state_d = ST_FIN;
        if (item_q.op == OP_ENQ) begin
          if (qcnt_q == CW'(QUEUE_DEPTH)) begin
            err_d = ERR_ENQ_FULL;
          end else begin
            lo_d = '0;
            hi_d = dcnt_q;
            if (dcnt_q != '0) begin
              rd_en   = 1'b1;
              rd_addr = mod_add(first_q, mid_of('0, dcnt_q));
              state_d = ST_SRCH;
            end else begin
              state_d = ST_WR;
            end
          end
        end else begin
          if (qcnt_q == '0) begin
            err_d = ERR_DEQ_EMPTY;
          end else begin
            head_d = mod_add(head_q, CW'(1));
            qcnt_d = qcnt_q - CW'(1);
            // front leaves with the oldest entry
            if ((dcnt_q != '0) && (fpos_q == head_q)) begin
              first_d = mod_add(first_q, CW'(1));
              dcnt_d  = dcnt_pop;
              if (dcnt_pop != '0) begin
                rd_en   = 1'b1;
                rd_addr = first_d;
                state_d = ST_POP;
              end
            end
          end
        end
      end
      ST_SRCH: begin
        if (rd_value < item_q.value) begin
          hi_d = mid_cur;
        end else begin
          lo_d = mid_cur + CW'(1);
        end
        if (lo_d < hi_d) begin
          rd_en   = 1'b1;
          rd_addr = mod_add(first_q, mid_of(lo_d, hi_d));
        end else begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        wr_en   = 1'b1;
        wr_addr = mod_add(first_q, lo_q);
        wr_data = {item_q.value, enq_pos};
        dcnt_d  = lo_q + CW'(1);
        qcnt_d  = qcnt_q + CW'(1);
        if (lo_q == '0) begin
          max_d  = item_q.value;
          fpos_d = enq_pos;
        end
        state_d = ST_FIN;
      end
      ST_POP: begin
        max_d   = rd_value;
        fpos_d  = rd_pos;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_d.total       = total_q;
        res_d.current_max = ((qcnt_q != '0) && (dcnt_q != '0)) ? max_q : '0;
        res_d.is_empty    = (qcnt_q == '0);
        res_d.error       = err_q;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      first_q <= '0;
      dcnt_q  <= '0;
      head_q  <= '0;
      qcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      first_q <= first_d;
      dcnt_q  <= dcnt_d;
      head_q  <= head_d;
      qcnt_q  <= qcnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prod_q <= prod_d;
    max_q  <= max_d;
    fpos_q <= fpos_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    err_q  <= err_d;
    res_q  <= res_d;
  end

  // deque memory; reads and writes of one beat never overlap, the sequencer orders them
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // deque entries are a subset of queued entries
  a_dcnt_le_qcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= qcnt_q)
    else $error("deque longer than queue");

  // newest entry always survives in the deque
  a_deque_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcnt_q != '0) |-> (dcnt_q != '0))
    else $error("deque empty while queue holds entries");

  // a result is only strobed once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while busy");

  // full refusal only when the queue is really full
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.error == ERR_ENQ_FULL)) |-> (qcnt_q == CW'(QUEUE_DEPTH)))
    else $error("enqueue refused on non-full queue");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import mqtws_pkg::*;

  localparam int unsigned QDEPTH       = 1024;  // predictor index widths below assume 1024
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [ValueW-1:0] VALUE_MAX = '1;

  // how the value of an enqueue beat is picked
  typedef enum int unsigned {
    VAL_RANDOM,
    VAL_NARROW,
    VAL_FALLING,
    VAL_EXTREME
  } value_style_e;

  // a beat waiting to go out, optionally held until all results are back
  typedef struct {
    mqtws_in_t item;
    bit        drain_first;
  } pending_beat_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  mqtws_in_t  item   = '0;
  logic       done_o;
  mqtws_out_t result_o;

  pending_beat_t beats_to_send[$];
  mqtws_out_t    expected_results[$];

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int          fill_level   = 0;     // queue occupancy as the stimulus generator sees it
  logic [ValueW-1:0] desc_level = '1;

  // sender pacing
  int          burst_left = 1;
  int          gap_left   = 0;
  pending_beat_t next_beat;

  // monitor scratch
  mqtws_out_t want_res;

  // mirror of the block state
  logic [ValueW-1:0] mirror_val [QDEPTH];
  logic [9:0]        mirror_pos [QDEPTH];
  logic [9:0]        mirror_first = '0;
  logic [10:0]       mirror_len   = '0;
  logic [9:0]        mirror_head  = '0;
  logic [10:0]       mirror_count = '0;
  logic [TotalW-1:0] mirror_total = '0;

  max_queue_time_weighted_sum #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // advances the mirrored queue by one beat and returns the result it should produce
  function automatic mqtws_out_t next_queue_result(input mqtws_in_t beat);
    mqtws_out_t        res;
    logic [TotalW-1:0] incr;
    logic [TotalW:0]   sum;
    logic [10:0]       lo;
    logic [10:0]       hi;
    logic [10:0]       mid;
    logic [9:0]        slot;
    logic [9:0]        pos;
    res       = '0;
    res.error = ERR_OK;
    // time passes first, weighted by the maximum held before this beat
    if (mirror_count != 0 && mirror_len != 0) begin
      incr = TotalW'(mirror_val[mirror_first]);
      incr = incr * beat.elapsed;
      sum  = {1'b0, mirror_total} + {1'b0, incr};
      mirror_total = sum[TotalW] ? '1 : sum[TotalW-1:0];
    end
    if (beat.op == OP_ENQ) begin
      if (mirror_count >= QDEPTH) begin
        res.error = ERR_ENQ_FULL;
      end else begin
        pos = mirror_head + mirror_count[9:0];
        // first deque entry strictly below the new value; equal ones stay
        lo = '0;
        hi = mirror_len;
        while (lo < hi) begin
          mid  = lo + ((hi - lo) >> 1);
          slot = mirror_first + mid[9:0];
          if (mirror_val[slot] < beat.value) begin
            hi = mid;
          end else begin
            lo = mid + 11'd1;
          end
        end
        slot = mirror_first + lo[9:0];
        mirror_val[slot] = beat.value;
        mirror_pos[slot] = pos;
        mirror_len       = lo + 11'd1;
        mirror_count     = mirror_count + 11'd1;
      end
    end else begin
      if (mirror_count == 0) begin
        res.error = ERR_DEQ_EMPTY;
      end else begin
        // the front leaves the deque only if it is the entry leaving the fifo
        if (mirror_len != 0 && mirror_pos[mirror_first] == mirror_head) begin
          mirror_first = mirror_first + 10'd1;
          mirror_len   = mirror_len - 11'd1;
        end
        mirror_head  = mirror_head + 10'd1;
        mirror_count = mirror_count - 11'd1;
      end
    end
    res.total       = mirror_total;
    res.current_max = (mirror_count != 0 && mirror_len != 0) ? mirror_val[mirror_first] : '0;
    res.is_empty    = (mirror_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  function automatic void queue_beat(input logic op, input logic [ElapsedW-1:0] elapsed,
                                     input logic [ValueW-1:0] value, input bit drain_first);
    pending_beat_t pb;
    pb.item.op      = op;
    pb.item.elapsed = elapsed;
    pb.item.value   = value;
    pb.drain_first  = drain_first;
    beats_to_send.push_back(pb);
    if (op == OP_ENQ && fill_level < QDEPTH) fill_level++;
    if (op == OP_DEQ && fill_level > 0) fill_level--;
  endfunction

  function automatic logic [ValueW-1:0] pick_value(input value_style_e style);
    logic [ValueW-1:0] v;
    case (style)
      VAL_RANDOM: begin
        v = ValueW'($urandom());
      end
      VAL_NARROW: begin
        v = ValueW'($urandom_range(0, 7));
      end
      VAL_FALLING: begin
        // slow descent with repeats builds a long deque
        if (desc_level < 4) begin
          desc_level = ValueW'($urandom()) | 31'h4000_0000;
        end else begin
          desc_level = desc_level - ValueW'($urandom_range(0, 3));
        end
        v = desc_level;
      end
      default: begin
        v = ($urandom_range(0, 1) != 0) ? VALUE_MAX : '0;
      end
    endcase
    return v;
  endfunction

  function automatic value_style_e pick_style(input int unsigned falling_pct);
    value_style_e s;
    if ($urandom_range(0, 99) < falling_pct) begin
      s = VAL_FALLING;
    end else begin
      s = value_style_e'($urandom_range(0, 3));
    end
    return s;
  endfunction

  // mostly short time steps so the total stays clear of saturation until the end
  function automatic logic [ElapsedW-1:0] pick_elapsed();
    int unsigned roll;
    logic [ElapsedW-1:0] e;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      e = '0;
    end else if (roll < 95) begin
      e = $urandom_range(0, 300);
    end else begin
      e = $urandom_range(0, 65535);
    end
    return e;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // driver: a beat is taken at the edge where start is high and busy is low
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(next_queue_result(item));
      end
      // start may change only when no beat is held waiting on busy
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beats_to_send.size() != 0 &&
                     !(beats_to_send[0].drain_first && expected_results.size() != 0)) begin
          next_beat = beats_to_send.pop_front();
          item  <= next_beat.item;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // new burst; now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o cycle carries one result, checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no beat outstanding");
      end else begin
        want_res = expected_results.pop_front();
        if (result_o.total !== want_res.total)
          report_mismatch($sformatf("total got %0h want %0h",
                                    result_o.total, want_res.total));
        if (result_o.current_max !== want_res.current_max)
          report_mismatch($sformatf("current_max got %0h want %0h",
                                    result_o.current_max, want_res.current_max));
        if (result_o.is_empty !== want_res.is_empty)
          report_mismatch($sformatf("is_empty got %0b want %0b",
                                    result_o.is_empty, want_res.is_empty));
        if (result_o.error !== want_res.error)
          report_mismatch($sformatf("error got %0d want %0d",
                                    result_o.error, want_res.error));
      end
    end
  end

  initial begin
    int n;
    // directed: empty queue, extremes, ties, front pops, wide time steps
    queue_beat(OP_DEQ, 32'hFFFF_FFFF, VALUE_MAX, 1'b0);     // dequeue on empty, no time added
    queue_beat(OP_ENQ, 32'h0000_0000, 31'h0, 1'b0);         // zero value
    queue_beat(OP_DEQ, 32'd5, 31'h0, 1'b0);                 // back to empty
    queue_beat(OP_ENQ, 32'd7, VALUE_MAX, 1'b0);
    queue_beat(OP_ENQ, 32'd1, 31'd100, 1'b0);
    queue_beat(OP_ENQ, 32'd3, 31'd100, 1'b0);               // equal value kept
    queue_beat(OP_ENQ, 32'd0, 31'd50, 1'b0);
    queue_beat(OP_ENQ, 32'd2, 31'd100, 1'b0);               // drops the smaller tail only
    queue_beat(OP_ENQ, 32'd9, 31'd200, 1'b0);               // drops the ties too
    queue_beat(OP_DEQ, 32'd4, 31'h7FFF_0000, 1'b0);         // front leaves with the head
    queue_beat(OP_DEQ, 32'd6, 31'h0, 1'b0);                 // front stays, head is not it
    queue_beat(OP_ENQ, 32'hFFFF_FFFF, 31'd1, 1'b0);
    queue_beat(OP_ENQ, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 1'b0);
    queue_beat(OP_ENQ, 32'h0005_5555, 31'h5555_5555, 1'b0);
    for (n = 0; n < 8; n++) begin
      queue_beat(OP_DEQ, 32'd11, 31'h0, 1'b0);              // empties, last one refused
    end
    queue_beat(OP_ENQ, 32'd3, 31'd12, 1'b1);                // after a full pause

    // mixed traffic around a shallow queue
    for (n = 0; n < 250; n++) begin
      queue_beat(($urandom_range(0, 1) != 0) ? OP_ENQ : OP_DEQ, pick_elapsed(),
                 pick_value(pick_style(30)), (n == 0));
    end

    // fill to the brim with mostly falling values, then knock on the full queue
    n = 0;
    while (fill_level < QDEPTH) begin
      queue_beat(($urandom_range(0, 99) < 97) ? OP_ENQ : OP_DEQ, pick_elapsed(),
                 pick_value(pick_style(75)), (n == 0));
      n++;
    end
    for (n = 0; n < 6; n++) begin
      queue_beat(OP_ENQ, pick_elapsed(), pick_value(VAL_RANDOM), (n == 3));
    end
    queue_beat(OP_DEQ, pick_elapsed(), 31'h0, 1'b0);
    queue_beat(OP_ENQ, pick_elapsed(), VALUE_MAX, 1'b0);
    queue_beat(OP_ENQ, pick_elapsed(), VALUE_MAX, 1'b0);    // refused, the queue is full again

    // drain-leaning traffic, deep deque pops and a trip back to empty
    for (n = 0; n < 250; n++) begin
      queue_beat(($urandom_range(0, 99) < 40) ? OP_ENQ : OP_DEQ, pick_elapsed(),
                 pick_value(pick_style(40)), (n == 0));
    end

    // wide time steps under a big maximum: the total saturates and must stick
    queue_beat(OP_ENQ, pick_elapsed(), VALUE_MAX, 1'b1);
    for (n = 0; n < 12; n++) begin
      queue_beat(($urandom_range(0, 3) != 0) ? OP_ENQ : OP_DEQ, ElapsedW'($urandom()),
                 pick_value(VAL_RANDOM), 1'b0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_to_send.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
